[rtl/core/tgc_pkg.sv]
`default_nettype none

package tgc_pkg;

    localparam int RAW_BITS   = 16;
    localparam int COUNT_BITS = 4;
    localparam int GEST_BITS  = 3;
    localparam int CFG_BITS   = 16;
    localparam int DIST_BITS  = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIRROR_ORIGIN  = 1'b1;

    localparam logic [CFG_BITS-1:0] MOVE_THRESHOLD_RESET = 16'd20;
    localparam logic [CFG_BITS-1:0] MIRROR_ORIGIN_RESET  = 16'd800;

    localparam logic [COUNT_BITS-1:0] ONE_POINT  = 4'd1;
    localparam logic [COUNT_BITS-1:0] TWO_POINTS = 4'd2;

    localparam logic [GEST_BITS-1:0] G_NONE         = 3'd0;
    localparam logic [GEST_BITS-1:0] G_SWIPE_X_UP   = 3'd1;
    localparam logic [GEST_BITS-1:0] G_SWIPE_X_DOWN = 3'd2;
    localparam logic [GEST_BITS-1:0] G_SWIPE_Y_UP   = 3'd3;
    localparam logic [GEST_BITS-1:0] G_SWIPE_Y_DOWN = 3'd4;
    localparam logic [GEST_BITS-1:0] G_LONG_PRESS   = 3'd5;
    localparam logic [GEST_BITS-1:0] G_ZOOM_IN      = 3'd6;
    localparam logic [GEST_BITS-1:0] G_ZOOM_OUT     = 3'd7;

    typedef struct packed {
        logic load;
        logic diff;
        logic square;
        logic sum;
        logic root;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic pinch_in;
    } t_status;

endpackage

`default_nettype wire

[rtl/core/tgc_in_if.sv]
`default_nettype none

interface tgc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            touched;
    logic [tgc_pkg::COUNT_BITS-1:0]  point_count;
    logic [tgc_pkg::RAW_BITS-1:0]    first_raw_x;
    logic [tgc_pkg::RAW_BITS-1:0]    first_raw_y;
    logic [tgc_pkg::RAW_BITS-1:0]    second_raw_x;
    logic [tgc_pkg::RAW_BITS-1:0]    second_raw_y;

    modport source (
        output valid, touched, point_count, first_raw_x, first_raw_y,
               second_raw_x, second_raw_y,
        input  ready
    );
    modport sink (
        input  valid, touched, point_count, first_raw_x, first_raw_y,
               second_raw_x, second_raw_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/tgc_out_if.sv]
`default_nettype none

interface tgc_out_if;
    logic                           valid;
    logic                           ready;
    logic [tgc_pkg::GEST_BITS-1:0]  gesture;

    modport source (output valid, gesture, input ready);
    modport sink (input valid, gesture, output ready);
endinterface

`default_nettype wire

[rtl/core/touch_gesture_classifier_core.sv]
`default_nettype none

// Classifies touch-controller scans into swipes, long presses and pinch zooms, one
// result per accepted scan. A scan with two touched points passes through the difference,
// square and sum steps and then the square root of the pinch distance, which resolves one
// result bit per cycle; any other scan goes straight to the finish step. The next scan
// is taken as soon as the block is back in its idle state, while the previous result
// may still wait in the output register for its transfer. Configuration is written
// through the plain write port, by the user only while idle; the block does not check it.
module touch_gesture_classifier_core #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [tgc_pkg::CFG_BITS-1:0]     i_cfg_data,
    tgc_in_if.sink                                i_in,
    tgc_out_if.source                             o_out
);

    tgc_pkg::t_cmd    w_cmd;
    tgc_pkg::t_status w_status;

    tgc_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tgc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_touched      (i_in.touched),
        .i_point_count  (i_in.point_count),
        .i_first_raw_x  (i_in.first_raw_x),
        .i_first_raw_y  (i_in.first_raw_y),
        .i_second_raw_x (i_in.second_raw_x),
        .i_second_raw_y (i_in.second_raw_y),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_gesture      (o_out.gesture)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted in two consecutive cycles");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command active");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finish command");

endmodule

`default_nettype wire

[rtl/core/tgc_ctrl.sv]
`default_nettype none

module tgc_ctrl #(
    parameter int COORD_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    input  tgc_pkg::t_status i_status,
    output tgc_pkg::t_cmd o_cmd
);

    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                w_fire;

    assign w_fire      = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.diff   = (r_state == S_DIFF);
        o_cmd.square = (r_state == S_SQUARE);
        o_cmd.sum    = (r_state == S_SUM);
        o_cmd.root   = (r_state == S_ROOT);
        o_cmd.finish = w_fire;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.pinch_in ? S_DIFF : S_FINISH;
                end
            end
            S_DIFF:   n_state = S_SQUARE;
            S_SQUARE: n_state = S_SUM;
            S_SUM: begin
                n_state = S_ROOT;
                n_cnt   = CNT_BITS'(ROOT_BITS - 1);
            end
            S_ROOT: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tgc_datapath.sv]
`default_nettype none

module tgc_datapath #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [tgc_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  wire logic                             i_touched,
    input  wire logic [tgc_pkg::COUNT_BITS-1:0]   i_point_count,
    input  wire logic [tgc_pkg::RAW_BITS-1:0]     i_first_raw_x,
    input  wire logic [tgc_pkg::RAW_BITS-1:0]     i_first_raw_y,
    input  wire logic [tgc_pkg::RAW_BITS-1:0]     i_second_raw_x,
    input  wire logic [tgc_pkg::RAW_BITS-1:0]     i_second_raw_y,
    input  tgc_pkg::t_cmd                         i_cmd,
    output tgc_pkg::t_status                      o_status,
    output logic [tgc_pkg::GEST_BITS-1:0]         o_gesture
);

    localparam int CB        = COORD_BITS;
    localparam int ROOT_BITS = CB + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;

    logic [tgc_pkg::CFG_BITS-1:0] r_thr, r_origin;

    logic [CB-1:0] r_held_x, r_held_y;
    logic          r_single, r_pinch;
    logic [tgc_pkg::DIST_BITS-1:0] r_start_dist;

    logic                            r_touched;
    logic [tgc_pkg::COUNT_BITS-1:0]  r_count;
    logic [CB-1:0]                   r_x0, r_y0, r_x1, r_y1;
    logic [CB-1:0]                   r_dx, r_dy;
    logic [2*CB-1:0]                 r_sqx, r_sqy;
    logic [RAD_BITS-1:0]             r_rad;
    logic [REM_BITS-1:0]             r_rem;
    logic [ROOT_BITS-1:0]            r_root;
    logic [tgc_pkg::GEST_BITS-1:0]   r_gesture;

    logic [tgc_pkg::RAW_BITS-1:0] w_mx0, w_mx1;
    logic [REM_BITS+1:0]          w_rem_sh, w_trial;
    logic [31:0]                  w_root32;
    logic [tgc_pkg::DIST_BITS-1:0] w_dist, w_ddist;
    logic [CB-1:0]                w_dx1, w_dy1;
    logic [tgc_pkg::GEST_BITS-1:0] w_gest;

    assign o_status.pinch_in = i_touched && (i_point_count == tgc_pkg::TWO_POINTS);
    assign o_gesture = r_gesture;

    assign w_mx0 = r_origin - i_first_raw_x;
    assign w_mx1 = r_origin - i_second_raw_x;

    assign w_rem_sh = {r_rem, r_rad[RAD_BITS-1 -: 2]};
    assign w_trial  = (REM_BITS + 2)'({r_root, 2'b01});

    assign w_root32 = 32'(r_root);
    assign w_dist   = (w_root32 > 32'h0000_FFFF) ? 16'hFFFF : w_root32[15:0];
    assign w_ddist  = (r_start_dist > w_dist) ? (r_start_dist - w_dist)
                                              : (w_dist - r_start_dist);
    assign w_dx1    = (r_held_x > r_x0) ? (r_held_x - r_x0) : (r_x0 - r_held_x);
    assign w_dy1    = (r_held_y > r_y0) ? (r_held_y - r_y0) : (r_y0 - r_held_y);

    always_comb begin
        w_gest = tgc_pkg::G_NONE;
        if (r_touched && (r_count == tgc_pkg::ONE_POINT) && r_single) begin
            priority if ((w_dx1 > w_dy1) && (16'(w_dx1) > r_thr)) begin
                w_gest = (r_held_x < r_x0) ? tgc_pkg::G_SWIPE_X_UP
                                           : tgc_pkg::G_SWIPE_X_DOWN;
            end else if ((w_dy1 > w_dx1) && (16'(w_dy1) > r_thr)) begin
                w_gest = (r_held_y < r_y0) ? tgc_pkg::G_SWIPE_Y_UP
                                           : tgc_pkg::G_SWIPE_Y_DOWN;
            end else if ((r_held_x == r_x0) && (r_held_y == r_y0)) begin
                w_gest = tgc_pkg::G_LONG_PRESS;
            end
        end else if (r_touched && (r_count == tgc_pkg::TWO_POINTS) && r_pinch) begin
            if (w_ddist > r_thr) begin
                w_gest = (r_start_dist < w_dist) ? tgc_pkg::G_ZOOM_IN
                                                 : tgc_pkg::G_ZOOM_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= tgc_pkg::MOVE_THRESHOLD_RESET;
            r_origin     <= tgc_pkg::MIRROR_ORIGIN_RESET;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_single     <= 1'b0;
            r_pinch      <= 1'b0;
            r_start_dist <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tgc_pkg::CFG_MOVE_THRESHOLD) begin
                    r_thr <= i_cfg_data;
                end else if (i_cfg_idx == tgc_pkg::CFG_MIRROR_ORIGIN) begin
                    r_origin <= i_cfg_data;
                end
            end
            if (i_cmd.finish && r_touched) begin
                if (r_count == tgc_pkg::ONE_POINT) begin
                    if (!r_single) begin
                        r_held_x <= r_x0;
                        r_held_y <= r_y0;
                        r_single <= 1'b1;
                    end else begin
                        r_single <= 1'b0;
                    end
                end else if (r_count == tgc_pkg::TWO_POINTS) begin
                    r_held_x <= r_x0;
                    r_held_y <= r_y0;
                    if (!r_pinch) begin
                        r_pinch      <= 1'b1;
                        r_start_dist <= w_dist;
                    end else begin
                        r_pinch      <= 1'b0;
                        r_start_dist <= '0;
                    end
                end else begin
                    r_single     <= 1'b0;
                    r_pinch      <= 1'b0;
                    r_start_dist <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_touched <= i_touched;
            r_count   <= i_point_count;
            r_x0      <= w_mx0[CB-1:0];
            r_y0      <= i_first_raw_y[CB-1:0];
            r_x1      <= w_mx1[CB-1:0];
            r_y1      <= i_second_raw_y[CB-1:0];
        end
        if (i_cmd.diff) begin
            r_dx <= (r_x0 > r_x1) ? (r_x0 - r_x1) : (r_x1 - r_x0);
            r_dy <= (r_y0 > r_y1) ? (r_y0 - r_y1) : (r_y1 - r_y0);
        end
        if (i_cmd.square) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
        end
        if (i_cmd.sum) begin
            r_rad  <= RAD_BITS'(r_sqx) + RAD_BITS'(r_sqy);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root) begin
            r_rad <= {r_rad[RAD_BITS-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= REM_BITS'(w_rem_sh - w_trial);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= REM_BITS'(w_rem_sh);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_gesture <= w_gest;
        end
    end

endmodule

`default_nettype wire

[sim/gesture_checker.sv]
module gesture_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [tgc_pkg::CFG_BITS-1:0]     i_cfg_data,
    tgc_in_if                                     scan_mon,
    tgc_out_if                                    gest_mon,
    output int                                    o_mismatches,
    output int                                    o_waiting
);
    import tgc_pkg::*;

    logic [CFG_BITS-1:0]  threshold;
    logic [CFG_BITS-1:0]  origin;
    logic [RAW_BITS-1:0]  held_x;
    logic [RAW_BITS-1:0]  held_y;
    logic                 single_armed;
    logic                 pinch_armed;
    logic [DIST_BITS-1:0] start_span;
    logic [GEST_BITS-1:0] expected_gestures[$];
    int                   fail_n;

    function automatic logic [RAW_BITS-1:0] coord_gap(input logic [RAW_BITS-1:0] a,
                                                      input logic [RAW_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Floor of the Euclidean distance, saturated at 16'hFFFF, found one result bit at a time.
    function automatic logic [DIST_BITS-1:0] pinch_span(input logic [RAW_BITS-1:0] ax,
                                                        input logic [RAW_BITS-1:0] ay,
                                                        input logic [RAW_BITS-1:0] bx,
                                                        input logic [RAW_BITS-1:0] by);
        logic [33:0] sq;
        logic [17:0] root;
        logic [17:0] trial;
        logic [35:0] trial_sq;
        sq = 34'(coord_gap(ax, bx)) * 34'(coord_gap(ax, bx))
           + 34'(coord_gap(ay, by)) * 34'(coord_gap(ay, by));
        root = '0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (18'd1 << b);
            trial_sq = 36'(trial) * 36'(trial);
            if (trial_sq <= 36'(sq)) begin
                root = trial;
            end
        end
        return (root > 18'hFFFF) ? 16'hFFFF : root[15:0];
    endfunction

    function automatic logic [GEST_BITS-1:0] predict_gesture(
        input logic                  touched,
        input logic [COUNT_BITS-1:0] count,
        input logic [RAW_BITS-1:0]   rx0,
        input logic [RAW_BITS-1:0]   ry0,
        input logic [RAW_BITS-1:0]   rx1,
        input logic [RAW_BITS-1:0]   ry1
    );
        logic [RAW_BITS-1:0]  x0;
        logic [RAW_BITS-1:0]  x1;
        logic [RAW_BITS-1:0]  dx;
        logic [RAW_BITS-1:0]  dy;
        logic [DIST_BITS-1:0] span;
        logic [GEST_BITS-1:0] g;
        g = G_NONE;
        x0 = origin - rx0;
        x1 = origin - rx1;
        if (touched) begin
            if (count == ONE_POINT) begin
                if (!single_armed) begin
                    held_x = x0;
                    held_y = ry0;
                    single_armed = 1'b1;
                end else begin
                    dx = coord_gap(held_x, x0);
                    dy = coord_gap(held_y, ry0);
                    single_armed = 1'b0;
                    if (dx > dy && dx > threshold) begin
                        g = (held_x < x0) ? G_SWIPE_X_UP : G_SWIPE_X_DOWN;
                    end else if (dy > dx && dy > threshold) begin
                        g = (held_y < ry0) ? G_SWIPE_Y_UP : G_SWIPE_Y_DOWN;
                    end else if (held_x == x0 && held_y == ry0) begin
                        g = G_LONG_PRESS;
                    end
                end
            end else if (count == TWO_POINTS) begin
                span = pinch_span(x0, ry0, x1, ry1);
                held_x = x0;
                held_y = ry0;
                if (!pinch_armed) begin
                    pinch_armed = 1'b1;
                    start_span = span;
                end else begin
                    pinch_armed = 1'b0;
                    if (coord_gap(start_span, span) > threshold) begin
                        g = (start_span < span) ? G_ZOOM_IN : G_ZOOM_OUT;
                    end
                    start_span = '0;
                end
            end else begin
                single_armed = 1'b0;
                pinch_armed = 1'b0;
                start_span = '0;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [GEST_BITS-1:0] want;
        if (!i_rst_n) begin
            threshold = MOVE_THRESHOLD_RESET;
            origin = MIRROR_ORIGIN_RESET;
            held_x = '0;
            held_y = '0;
            single_armed = 1'b0;
            pinch_armed = 1'b0;
            start_span = '0;
            fail_n = 0;
            expected_gestures.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOVE_THRESHOLD: threshold = i_cfg_data;
                    CFG_MIRROR_ORIGIN:  origin = i_cfg_data;
                endcase
            end
            if (scan_mon.valid && scan_mon.ready) begin
                expected_gestures.push_back(predict_gesture(scan_mon.touched,
                    scan_mon.point_count, scan_mon.first_raw_x, scan_mon.first_raw_y,
                    scan_mon.second_raw_x, scan_mon.second_raw_y));
            end
            if (gest_mon.valid && gest_mon.ready) begin
                if (expected_gestures.size() == 0) begin
                    if (fail_n < 10) begin
                        $display("unexpected gesture transfer: got %0d", gest_mon.gesture);
                    end
                    fail_n++;
                end else begin
                    want = expected_gestures.pop_front();
                    if (want != gest_mon.gesture) begin
                        if (fail_n < 10) begin
                            $display("gesture mismatch: expected %0d, got %0d",
                                     want, gest_mon.gesture);
                        end
                        fail_n++;
                    end
                end
            end
        end
        o_waiting <= expected_gestures.size();
        o_mismatches <= fail_n;
    end

endmodule

[sim/tb_top.sv]
module tb_top;
    import tgc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 145;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;

    int                      mismatches;
    int                      waiting;
    int                      cycles = 0;
    logic [15:0]             rx_tick = '0;
    int                      burst_left = 1;
    int                      gap_max = 12;
    int                      phase_sent;
    logic [CFG_BITS-1:0]     cur_thr = MOVE_THRESHOLD_RESET;

    tgc_in_if  scan_ch();
    tgc_out_if gest_ch();

    touch_gesture_classifier_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (scan_ch),
        .o_out      (gest_ch)
    );

    gesture_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .scan_mon     (scan_ch),
        .gest_mon     (gest_ch),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** touch_gesture_classifier_core: FAILED **");
            $finish;
        end
    end

    // The receiver cycles through always ready, light random stalls, long stalls
    // and coin-flip readiness.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 16'd1;
        case (rx_tick[10:9])
            2'd0: gest_ch.ready <= 1'b1;
            2'd1: gest_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: gest_ch.ready <= (rx_tick[4:0] < 5'd6);
            default: gest_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic send_scan(input logic touched, input logic [COUNT_BITS-1:0] count,
                             input logic [RAW_BITS-1:0] ax, input logic [RAW_BITS-1:0] ay,
                             input logic [RAW_BITS-1:0] bx, input logic [RAW_BITS-1:0] by);
        int gap;
        scan_ch.valid <= 1'b1;
        scan_ch.touched <= touched;
        scan_ch.point_count <= count;
        scan_ch.first_raw_x <= ax;
        scan_ch.first_raw_y <= ay;
        scan_ch.second_raw_x <= bx;
        scan_ch.second_raw_y <= by;
        @(posedge i_clk);
        while (!scan_ch.ready) @(posedge i_clk);
        phase_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                scan_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        scan_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] org);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_MOVE_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx <= CFG_MIRROR_ORIGIN;
        i_cfg_data <= org;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_thr = thr;
    endtask

    function automatic logic [RAW_BITS-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 1023));
            1: return 16'hFFFF - 16'($urandom_range(0, 63));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_BITS-1:0] pick_delta();
        logic [RAW_BITS-1:0] mag;
        case ($urandom_range(0, 5))
            0: mag = '0;
            1: mag = cur_thr;
            2: mag = cur_thr + 16'd1;
            3: mag = cur_thr - 16'd1;
            4: mag = 16'($urandom_range(0, 64));
            default: mag = 16'($urandom);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic play_swipe();
        logic [RAW_BITS-1:0] x;
        logic [RAW_BITS-1:0] y;
        logic [RAW_BITS-1:0] mx;
        logic [RAW_BITS-1:0] my;
        x = pick_coord();
        y = pick_coord();
        send_scan(1'b1, ONE_POINT, x, y, 16'($urandom), 16'($urandom));
        case ($urandom_range(0, 4))
            0: begin
                mx = pick_delta();
                my = 16'($urandom_range(0, 3));
            end
            1: begin
                mx = 16'($urandom_range(0, 3));
                my = pick_delta();
            end
            2: begin
                mx = pick_delta();
                my = pick_delta();
            end
            3: begin
                mx = '0;
                my = '0;
            end
            default: begin
                mx = pick_delta();
                my = $urandom_range(0, 1) ? mx : -mx;
            end
        endcase
        send_scan(1'b1, ONE_POINT, x + mx, y + my, 16'($urandom), 16'($urandom));
    endtask

    task automatic play_pinch();
        logic [RAW_BITS-1:0] ax;
        logic [RAW_BITS-1:0] ay;
        logic [RAW_BITS-1:0] bx;
        logic [RAW_BITS-1:0] by;
        ax = pick_coord();
        ay = pick_coord();
        bx = pick_coord();
        by = pick_coord();
        send_scan(1'b1, TWO_POINTS, ax, ay, bx, by);
        if ($urandom_range(0, 5) == 0) begin
            bx = ax;
            by = ay;
        end else begin
            bx = bx + pick_delta();
            if ($urandom_range(0, 1)) begin
                by = by + pick_delta();
            end
            if ($urandom_range(0, 3) == 0) begin
                ax = ax + 16'($urandom_range(0, 7));
            end
        end
        send_scan(1'b1, TWO_POINTS, ax, ay, bx, by);
    endtask

    task automatic play_noise();
        logic [COUNT_BITS-1:0] odd_count;
        odd_count = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(3, 15));
        case ($urandom_range(0, 3))
            0: send_scan(1'b0, 4'($urandom), pick_coord(), pick_coord(), pick_coord(),
                         pick_coord());
            1: send_scan(1'b1, odd_count, pick_coord(), pick_coord(), pick_coord(),
                         pick_coord());
            2: send_scan(1'b1, ONE_POINT, pick_coord(), pick_coord(), 16'($urandom),
                         16'($urandom));
            default: send_scan(1'b1, TWO_POINTS, pick_coord(), pick_coord(), pick_coord(),
                               pick_coord());
        endcase
    endtask

    initial begin
        int pick;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MOVE_THRESHOLD;
        i_cfg_data = '0;
        scan_ch.valid = 1'b0;
        scan_ch.touched = 1'b0;
        scan_ch.point_count = '0;
        scan_ch.first_raw_x = '0;
        scan_ch.first_raw_y = '0;
        scan_ch.second_raw_x = '0;
        scan_ch.second_raw_y = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed scans under the reset settings: threshold 20, mirror origin 800.
        send_scan(1'b0, ONE_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd650, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd750, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd340, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd260, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd670, 16'd330, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd700, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd720, 16'd300, 16'd0, 16'd0);
        send_scan(1'b1, TWO_POINTS, 16'd800, 16'd0, 16'd801, 16'hFFFF);
        send_scan(1'b1, TWO_POINTS, 16'd800, 16'd0, 16'd700, 16'd0);
        send_scan(1'b1, TWO_POINTS, 16'd800, 16'd0, 16'd700, 16'd0);
        send_scan(1'b1, TWO_POINTS, 16'd800, 16'd0, 16'd600, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'd0, 16'd0, 16'd0, 16'd0);
        send_scan(1'b1, 4'd3, 16'd0, 16'd0, 16'd0, 16'd0);
        send_scan(1'b1, ONE_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_scan(1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_scan(1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_scan(1'b0, TWO_POINTS, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: write_regs(16'd0, 16'd0);
                    2: write_regs(16'hFFFF, 16'hFFFF);
                    3: write_regs(16'd0, 16'hFFFF);
                    default: write_regs(16'($urandom_range(0, 200)), 16'($urandom));
                endcase
            end
            gap_max = (ph % 3 == 1) ? 0 : 12;
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    play_swipe();
                end else if (pick < 80) begin
                    play_pinch();
                end else begin
                    play_noise();
                end
            end
        end

        settle();
        if (mismatches == 0 && waiting == 0) begin
            $display("** touch_gesture_classifier_core: PASSED **");
        end else begin
            $display("** touch_gesture_classifier_core: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tgc_pkg.sv
rtl/core/tgc_in_if.sv
rtl/core/tgc_out_if.sv
rtl/core/tgc_ctrl.sv
rtl/core/tgc_datapath.sv
rtl/core/touch_gesture_classifier_core.sv
sim/gesture_checker.sv
sim/tb_top.sv
